FILE: rtl/edf_task_scheduler_top_macros.svh
// Assertion macros for the EDF task scheduler
`ifndef EDF_TASK_SCHEDULER_TOP_MACROS_SVH
`define EDF_TASK_SCHEDULER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define EDF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("edf assertion failed");
`define EDF_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("edf assertion failed");
`else
`define EDF_ASSERT(lbl, prop)
`define EDF_ASSERT_RST(lbl, prop)
`endif
`endif

FILE: rtl/edf_pkg.sv
// Shared types, codes and helpers for the EDF task scheduler
`timescale 1ns / 1ps
package edf_pkg;

    localparam int IN_DATA_W  = 104;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 128;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_STATS = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREEMPT,
        S_RUN,
        S_EXPIRE,
        S_DONE
    } t_state;

    // first field in the highest bits
    typedef struct packed {
        logic [4:0]  pad;
        logic [31:0] resp_ticks;
        logic [15:0] missed_count;
        logic [15:0] preempt_count;
        logic [30:0] now_time;
        logic [15:0] missed_mask;
        logic        finished;
        logic [3:0]  preempted_task;
        logic        preempted;
        logic        started;
        logic        cpu_idle;
        logic [3:0]  run_task;
    } t_result;

    typedef struct packed {
        logic accept;
        logic scan;
        logic preempt;
        logic run;
        logic expire;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_last;
        logic out_busy;
    } t_dp_sts;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v != CNT_MAX) ? v + 16'd1 : v;
    endfunction

endpackage

FILE: rtl/edf_ctrl.sv
// Sequencer for load, stats read and tick processing
`timescale 1ns / 1ps
`include "edf_task_scheduler_top_macros.svh"
module edf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  edf_pkg::t_func  i_func,
    output logic            o_in_ready,
    input  edf_pkg::t_dp_sts i_sts,
    output edf_pkg::t_dp_cmd o_cmd
);
    import edf_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_func == FUNC_TICK) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (i_sts.idx_last) n_state = S_PREEMPT;
            end
            S_PREEMPT: n_state = S_RUN;
            S_RUN:     n_state = S_EXPIRE;
            S_EXPIRE: begin
                if (i_sts.idx_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_SCAN:    o_cmd.scan    = 1'b1;
            S_PREEMPT: o_cmd.preempt = 1'b1;
            S_RUN:     o_cmd.run     = 1'b1;
            S_EXPIRE:  o_cmd.expire  = 1'b1;
            S_DONE:    o_cmd.out_load = !i_sts.out_busy;
            default: ;
        endcase
    end

    `EDF_ASSERT(a_tick_enters_scan,
        (r_state == S_IDLE && i_in_valid && i_func == FUNC_TICK) |=> (r_state == S_SCAN))
    `EDF_ASSERT(a_one_cmd, $onehot0({o_cmd.accept, o_cmd.scan, o_cmd.preempt,
        o_cmd.run, o_cmd.expire, o_cmd.out_load}))
    `EDF_ASSERT_RST(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE))

endmodule

FILE: rtl/edf_dp.sv
// Task table, deadline scan, run and expiry datapath with result register
`timescale 1ns / 1ps
`include "edf_task_scheduler_top_macros.svh"
module edf_dp #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 31
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [edf_pkg::IN_DATA_W-1:0]      i_in_data,
    input  edf_pkg::t_func                     i_func,
    input  edf_pkg::t_dp_cmd                   i_cmd,
    output edf_pkg::t_dp_sts                   o_sts,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output edf_pkg::t_result                   o_out
);
    import edf_pkg::*;

    localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int TB = TIME_BITS;

    // input fields
    logic [3:0]  in_slot;
    logic        in_periodic;
    logic [15:0] in_exec, in_period;
    logic [30:0] in_release, in_deadline;
    assign in_slot     = i_in_data[3:0];
    assign in_periodic = i_in_data[4];
    assign in_exec     = i_in_data[20:5];
    assign in_period   = i_in_data[36:21];
    assign in_release  = i_in_data[67:37];
    assign in_deadline = i_in_data[98:68];

    logic          r_valid    [MAX_TASKS];
    logic          r_periodic [MAX_TASKS];
    logic [15:0]   r_exec     [MAX_TASKS];
    logic [15:0]   r_period   [MAX_TASKS];
    logic [TB-1:0] r_release  [MAX_TASKS];
    logic [TB-1:0] r_deadline [MAX_TASKS];
    logic [15:0]   r_rem      [MAX_TASKS];
    logic [15:0]   r_preempts [MAX_TASKS];
    logic [15:0]   r_misses   [MAX_TASKS];
    logic [TB-1:0] r_finish   [MAX_TASKS];

    logic          r_cur_valid, r_last_fin, r_found, r_out_valid;
    logic [SW-1:0] r_cur, r_pick, r_idx;
    logic [TB-1:0] r_tick, r_best;
    t_result       r_res, r_out;
    t_result       acc_res;

    logic [SW-1:0] a, slot_idx;
    logic          slot_ok, load_ok, stats_ok;
    logic          elig, pre_cond, start_cond, exp_hit;
    logic [15:0]   rem_dec;
    logic [6:0]    idx_ext;

    assign slot_idx = SW'(in_slot);
    assign slot_ok  = (7'(in_slot) < 7'(MAX_TASKS));
    assign load_ok  = i_cmd.accept && i_func == FUNC_LOAD && slot_ok;
    assign stats_ok = slot_ok && r_valid[slot_idx];

    always_comb begin
        priority if (i_cmd.accept) a = slot_idx;
        else if (i_cmd.preempt)    a = r_cur;
        else if (i_cmd.run)        a = r_pick;
        else                       a = r_idx;
    end

    assign elig = r_valid[a] && r_rem[a] != 16'd0 && (r_periodic[a] || r_release[a] <= r_tick);
    assign pre_cond   = r_cur_valid && (!r_found || r_cur != r_pick) && !r_last_fin;
    assign start_cond = r_found && (!r_cur_valid || r_cur != r_pick);
    assign rem_dec    = r_rem[a] - 16'd1;
    assign exp_hit    = r_valid[a] && r_deadline[a] != '0 && r_tick == r_deadline[a] - TB'(1);
    assign idx_ext    = 7'(r_idx);

    assign o_sts.idx_last = (32'(r_idx) == MAX_TASKS - 1);
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    // result seed taken at the input transfer
    always_comb begin
        acc_res          = '0;
        acc_res.now_time = 31'(r_tick);
        if (i_func == FUNC_STATS && stats_ok) begin
            acc_res.preempt_count = r_preempts[a];
            acc_res.missed_count  = r_misses[a];
            if (!r_periodic[a]) begin
                acc_res.resp_ticks = 32'(64'(r_finish[a]) - 64'(r_release[a]));
            end
        end
    end

    // table payload and result staging
    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            r_periodic[a] <= in_periodic;
            r_exec[a]     <= in_exec;
            r_period[a]   <= in_period;
            r_release[a]  <= TB'(in_release);
            r_deadline[a] <= TB'(in_deadline);
            r_rem[a]      <= in_exec;
            r_preempts[a] <= '0;
            r_misses[a]   <= '0;
            r_finish[a]   <= '0;
        end
        if (i_cmd.accept) r_res <= acc_res;
        if (i_cmd.scan && elig && (!r_found || r_deadline[a] < r_best)) begin
            r_best <= r_deadline[a];
            r_pick <= a;
        end
        if (i_cmd.preempt) begin
            if (pre_cond) begin
                r_preempts[a]        <= sat_inc(r_preempts[a]);
                r_res.preempted      <= 1'b1;
                r_res.preempted_task <= 4'(r_cur);
            end
            r_res.started <= start_cond;
        end
        if (i_cmd.run) begin
            if (r_found) begin
                r_res.run_task <= 4'(r_pick);
                r_rem[a]       <= rem_dec;
                if (rem_dec == 16'd0) begin
                    r_res.finished <= 1'b1;
                    if (!r_periodic[a]) r_finish[a] <= r_tick;
                end
            end else begin
                r_res.cpu_idle <= 1'b1;
            end
        end
        if (i_cmd.expire && exp_hit) begin
            if (r_rem[a] != 16'd0) begin
                r_misses[a] <= sat_inc(r_misses[a]);
                if (idx_ext < 7'd16) r_res.missed_mask[idx_ext[3:0]] <= 1'b1;
                if (!r_periodic[a]) r_finish[a] <= r_tick;
            end
            if (r_periodic[a]) begin
                r_rem[a]      <= r_exec[a];
                r_deadline[a] <= TB'(r_deadline[a] + TB'(r_period[a]));
            end else begin
                r_rem[a] <= '0;
            end
        end
        if (i_cmd.out_load) r_out <= r_res;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TASKS; i++) r_valid[i] <= 1'b0;
            r_cur_valid <= 1'b0;
            r_cur       <= '0;
            r_last_fin  <= 1'b0;
            r_found     <= 1'b0;
            r_tick      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_ok) r_valid[a] <= 1'b1;
            if (i_cmd.accept) r_found <= 1'b0;
            if (i_cmd.scan && elig) r_found <= 1'b1;
            if (i_cmd.scan || i_cmd.expire) begin
                r_idx <= o_sts.idx_last ? '0 : r_idx + SW'(1);
            end
            if (i_cmd.preempt) begin
                r_cur_valid <= r_found;
                r_cur       <= r_found ? r_pick : '0;
            end
            if (i_cmd.run && r_found) r_last_fin <= (rem_dec == 16'd0);
            if (i_cmd.expire && exp_hit && r_rem[a] != 16'd0) r_last_fin <= 1'b1;
            if (i_cmd.expire && o_sts.idx_last) r_tick <= r_tick + TB'(1);
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `EDF_ASSERT(a_idle_no_run, (r_out_valid && r_out.cpu_idle) |->
        (!r_out.finished && !r_out.started && r_out.run_task == 4'd0))
    `EDF_ASSERT(a_preempt_starts, (r_out_valid && r_out.preempted && !r_out.cpu_idle) |->
        r_out.started)
    `EDF_ASSERT(a_idx_home, (i_cmd.accept) |-> (r_idx == '0))

endmodule

FILE: rtl/edf_task_scheduler_top.sv
// Top level of the earliest-deadline-first task scheduler
`timescale 1ns / 1ps
// Usage:
//   Input stream s_axis: tuser carries the operation (load slot, tick, stats
//   read, no operation); tdata carries the task fields. Output stream m_axis
//   returns one result per input transfer.
//   Load, stats read and no-operation items go from idle to a done state that
//   loads the result register, then back to idle for the next transfer. A
//   tick steps through the deadline search over every slot, the preemption
//   accounting, the run of the chosen task, the deadline expiry pass over
//   every slot and the hand-over of the result. The two slot passes go
//   through the table one entry per cycle, so one item is processed at a
//   time.
//   Results sit in an output register; the next input transfer is accepted
//   while a result waits. If the receiver stalls, the following result is
//   held internally until the output register frees, and no new input is
//   taken meanwhile.
//   Reset clears all slot valid bits, the current task, the finish flag and
//   the tick counter; no output is pending after reset.
module edf_task_scheduler_top #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 31
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // slot, periodic flag, execution time, period, release tick, first deadline
    input  logic [edf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // func
    input  logic [edf_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // run_task, cpu_idle, started, preempted, preempted_task, finished,
    // missed_mask, now_time, preempt_count, missed_count, response ticks
    output logic [edf_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import edf_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_func   func;
    t_result res;

    assign func         = t_func'(s_axis_tuser);
    assign m_axis_tdata = res;

    edf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_func     (func),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    edf_dp #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_func      (func),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out       (res)
    );

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the EDF task scheduler top level
`timescale 1ns / 1ps
module testbench;
    import edf_pkg::*;

    typedef struct packed {
        t_func       func;
        logic [3:0]  slot;
        logic        periodic;
        logic [15:0] exec_t;
        logic [15:0] period;
        logic [30:0] release_t;
        logic [30:0] deadline;
    } t_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [IN_USER_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    edf_task_scheduler_top dut (.*);

    initial forever #6 i_clk = ~i_clk;

    // scheduler shadow
    logic        sh_valid [16];
    logic        sh_per [16];
    logic [15:0] sh_exec [16];
    logic [15:0] sh_period [16];
    logic [30:0] sh_rel [16];
    logic [30:0] sh_dl [16];
    logic [15:0] sh_rem [16];
    logic [15:0] sh_pre [16];
    logic [15:0] sh_miss [16];
    logic [30:0] sh_fin [16];
    logic        sh_cur_v;
    logic [3:0]  sh_cur;
    logic        sh_fin_flag;
    logic [30:0] sh_now;

    t_cmd    pending_cmds[$];
    t_result expected_results[$];
    int errors = 0, n_ticks = 0, n_sent = 0, n_got = 0, n_miss = 0;
    bit quiet_phase = 0;
    bit in_xfer = 0;

    function automatic logic [15:0] bump(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic t_result schedule_step(t_cmd c);
        t_result r;
        logic found;
        logic [3:0] pick;
        logic [30:0] best;
        logic [30:0] now;
        r = '0;
        now = sh_now;
        r.now_time = now;
        found = 0; pick = 0; best = 0;
        case (c.func)
            FUNC_LOAD: begin
                sh_valid[c.slot] = 1; sh_per[c.slot] = c.periodic;
                sh_exec[c.slot] = c.exec_t; sh_period[c.slot] = c.period;
                sh_rel[c.slot] = c.release_t; sh_dl[c.slot] = c.deadline;
                sh_rem[c.slot] = c.exec_t; sh_pre[c.slot] = 0;
                sh_miss[c.slot] = 0; sh_fin[c.slot] = 0;
            end
            FUNC_STATS: begin
                if (sh_valid[c.slot]) begin
                    r.preempt_count = sh_pre[c.slot];
                    r.missed_count = sh_miss[c.slot];
                    if (!sh_per[c.slot])
                        r.resp_ticks = {1'b0, sh_fin[c.slot]} - {1'b0, sh_rel[c.slot]};
                end
            end
            FUNC_TICK: begin
                for (int i = 0; i < 16; i++) begin
                    if (!sh_valid[i] || sh_rem[i] == 0) continue;
                    if (!sh_per[i] && sh_rel[i] > now) continue;
                    if (!found || sh_dl[i] < best) begin
                        found = 1; best = sh_dl[i]; pick = 4'(i);
                    end
                end
                if (sh_cur_v && (!found || sh_cur != pick) && !sh_fin_flag) begin
                    sh_pre[sh_cur] = bump(sh_pre[sh_cur]);
                    r.preempted = 1; r.preempted_task = sh_cur;
                end
                if (found && (!sh_cur_v || sh_cur != pick)) r.started = 1;
                sh_cur_v = found;
                sh_cur = found ? pick : 4'd0;
                if (found) begin
                    r.run_task = pick;
                    sh_rem[pick] = sh_rem[pick] - 16'd1;
                    if (sh_rem[pick] == 0) begin
                        r.finished = 1;
                        if (!sh_per[pick]) sh_fin[pick] = now;
                        sh_fin_flag = 1;
                    end else sh_fin_flag = 0;
                end else r.cpu_idle = 1;
                for (int i = 0; i < 16; i++) begin
                    if (!sh_valid[i] || sh_dl[i] == 0) continue;
                    if (now != sh_dl[i] - 31'd1) continue;
                    if (sh_rem[i] > 0) begin
                        sh_miss[i] = bump(sh_miss[i]);
                        sh_fin_flag = 1;
                        r.missed_mask[i] = 1;
                        if (!sh_per[i]) sh_fin[i] = now;
                    end
                    if (sh_per[i]) begin
                        sh_rem[i] = sh_exec[i];
                        sh_dl[i] = sh_dl[i] + 31'(sh_period[i]);
                    end else sh_rem[i] = 0;
                end
                sh_now = sh_now + 31'd1;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("MISMATCH result %0d %s: got %0h expected %0h", n_got, what, got, want);
    endtask

    function automatic t_cmd mk(t_func f, int s, int p, int e, int per, int rel, int dl);
        t_cmd c;
        c.func = f; c.slot = 4'(s); c.periodic = 1'(p); c.exec_t = 16'(e);
        c.period = 16'(per); c.release_t = 31'(rel); c.deadline = 31'(dl);
        return c;
    endfunction

    function automatic t_cmd rand_load(int s);
        int base;
        base = n_ticks;
        return mk(FUNC_LOAD, s, $urandom_range(0, 1), $urandom_range(0, 6),
                  $urandom_range(1, 12), base + $urandom_range(0, 10),
                  ($urandom_range(0, 15) == 0) ? 0 : base + $urandom_range(1, 25));
    endfunction

    // driver
    int src_gap = 0;
    int snk_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_xfer) begin
                in_xfer = 1'b0;
                if (!quiet_phase && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 13);
            end
            if (src_gap > 0 && !quiet_phase) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= pending_cmds[0].func;
                s_axis_tdata <= {5'b0, pending_cmds[0].deadline, pending_cmds[0].release_t,
                                 pending_cmds[0].period, pending_cmds[0].exec_t,
                                 pending_cmds[0].periodic, pending_cmds[0].slot};
            end else s_axis_tvalid <= 1'b0;
            if (quiet_phase) m_axis_tready <= 1'b1;
            else if (snk_gap > 0) begin
                snk_gap--;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 6) == 0) begin
                snk_gap = $urandom_range(0, 12);
                m_axis_tready <= 1'b0;
            end else m_axis_tready <= 1'b1;
        end
    end

    // monitor and checker
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        t_result g, w;
        if (i_rst_n) begin
            idle_cycles++;
            if (s_axis_tvalid && s_axis_tready) begin
                idle_cycles = 0;
                if (pending_cmds[0].func == FUNC_TICK) n_ticks++;
                expected_results.push_back(schedule_step(pending_cmds[0]));
                void'(pending_cmds.pop_front());
                n_sent++;
                in_xfer = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                idle_cycles = 0;
                g = m_axis_tdata;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transfer", 32'(g.now_time), 32'd0);
                end else begin
                    w = expected_results.pop_front();
                    if (w.missed_mask != 0) n_miss++;
                    if (g.run_task != w.run_task)
                        report_mismatch("run_task", 32'(g.run_task), 32'(w.run_task));
                    if (g.cpu_idle != w.cpu_idle)
                        report_mismatch("cpu_idle", 32'(g.cpu_idle), 32'(w.cpu_idle));
                    if (g.started != w.started)
                        report_mismatch("started", 32'(g.started), 32'(w.started));
                    if (g.preempted != w.preempted)
                        report_mismatch("preempted", 32'(g.preempted), 32'(w.preempted));
                    if (g.preempted_task != w.preempted_task)
                        report_mismatch("preempted_task", 32'(g.preempted_task),
                                        32'(w.preempted_task));
                    if (g.finished != w.finished)
                        report_mismatch("finished", 32'(g.finished), 32'(w.finished));
                    if (g.missed_mask != w.missed_mask)
                        report_mismatch("missed_mask", 32'(g.missed_mask), 32'(w.missed_mask));
                    if (g.now_time != w.now_time)
                        report_mismatch("now_time", 32'(g.now_time), 32'(w.now_time));
                    if (g.preempt_count != w.preempt_count)
                        report_mismatch("preempt_count", 32'(g.preempt_count),
                                        32'(w.preempt_count));
                    if (g.missed_count != w.missed_count)
                        report_mismatch("missed_count", 32'(g.missed_count),
                                        32'(w.missed_count));
                    if (g.resp_ticks != w.resp_ticks)
                        report_mismatch("resp_ticks", g.resp_ticks, w.resp_ticks);
                end
                n_got++;
            end
            if (idle_cycles >= 2000) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("** edf_task_scheduler_top: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int total, k;
        for (int i = 0; i < 16; i++) begin
            sh_valid[i] = 0; sh_per[i] = 0; sh_exec[i] = 0; sh_period[i] = 0;
            sh_rel[i] = 0; sh_dl[i] = 0; sh_rem[i] = 0; sh_pre[i] = 0;
            sh_miss[i] = 0; sh_fin[i] = 0;
        end
        sh_cur_v = 0; sh_cur = 0; sh_fin_flag = 0; sh_now = 0;
        // directed: unloaded read, nop, idle tick, field extremes, ties, misses
        pending_cmds.push_back(mk(FUNC_STATS, 15, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_NOP, 0, 1, 16'hFFFF, 16'hFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF));
        pending_cmds.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_LOAD, 15, 1, 16'hFFFF, 16'hFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF));
        pending_cmds.push_back(mk(FUNC_LOAD, 0, 1, 2, 3, 0, 4));
        pending_cmds.push_back(mk(FUNC_LOAD, 1, 1, 2, 3, 0, 4));
        pending_cmds.push_back(mk(FUNC_LOAD, 2, 0, 1, 0, 2, 3));
        pending_cmds.push_back(mk(FUNC_LOAD, 3, 0, 5, 0, 0, 3));
        pending_cmds.push_back(mk(FUNC_LOAD, 4, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_LOAD, 5, 1, 0, 0, 0, 2));
        pending_cmds.push_back(mk(FUNC_LOAD, 6, 0, 1, 0, 31'h7FFFFFFF, 1));
        for (int i = 0; i < 6; i++) pending_cmds.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0));
        for (int s = 0; s < 7; s++) pending_cmds.push_back(mk(FUNC_STATS, s, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_STATS, 15, 0, 0, 0, 0, 0));
        total = 1900;
        k = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;
        while (k < total) begin
            wait (pending_cmds.size() < 4);
            if (k > total - 150) quiet_phase = 1;
            case ($urandom_range(0, 9))
                0, 1: pending_cmds.push_back(rand_load($urandom_range(0, 15)));
                2: pending_cmds.push_back(mk(FUNC_STATS, $urandom_range(0, 15), 0, 0, 0, 0, 0));
                3: pending_cmds.push_back(mk(FUNC_NOP, $urandom, $urandom, $urandom,
                                            $urandom, $urandom, $urandom));
                4: pending_cmds.push_back(mk(FUNC_LOAD, $urandom_range(0, 15), $urandom,
                                            $urandom, $urandom, $urandom, $urandom));
                default: pending_cmds.push_back(mk(FUNC_TICK, $urandom, $urandom, $urandom,
                                                  $urandom, $urandom, $urandom));
            endcase
            k++;
            @(posedge i_clk);
        end
        wait (pending_cmds.size() == 0 && expected_results.size() == 0);
        repeat (60) @(posedge i_clk);
        $display("Covered %0d transfers in, %0d results out, %0d ticks, %0d with misses",
                 n_sent, n_got, n_ticks, n_miss);
        if (errors == 0 && expected_results.size() == 0)
            $display("** edf_task_scheduler_top: PASSED **");
        else
            $display("** edf_task_scheduler_top: FAILED **");
        $finish;
    end
endmodule

FILE: edf_task_scheduler_top.f
+incdir+rtl
rtl/edf_pkg.sv
rtl/edf_ctrl.sv
rtl/edf_dp.sv
rtl/edf_task_scheduler_top.sv
tb/sv/testbench.sv
